// ----- design/lfsr33_pkg.sv -----
// Shared types, result codes and the LFSR step functions for the 33-bit random generator.
package lfsr33_pkg;

  localparam int unsigned WordWidth   = 32;
  localparam int unsigned ScaledWidth = 31;
  localparam int unsigned KindWidth   = 2;

  localparam logic [KindWidth-1:0] KIND_SEED     = 2'd0;
  localparam logic [KindWidth-1:0] KIND_FRACTION = 2'd1;
  localparam logic [KindWidth-1:0] KIND_INTEGER  = 2'd2;

  typedef struct packed {
    logic [KindWidth-1:0]   kind;
    logic [WordWidth-1:0]   fraction;
    logic [ScaledWidth-1:0] scaled;
  } result_t;

  typedef struct packed {
    logic                 overflow;
    logic [WordWidth-1:0] shift;
  } lfsr_state_t;

  // Thirty-two shifts of the generator, written as an independent XOR of at most
  // three old bits for every new bit. Bit k of the window is shift[k] for k below
  // 32 and the overflow bit for k equal to 32.
  function automatic lfsr_state_t advance32(input lfsr_state_t cur);
    logic [WordWidth:0]   w;
    logic [WordWidth-1:0] b;
    lfsr_state_t          nxt;
    w = {cur.overflow, cur.shift};
    for (int t = 0; t < 32; t++) begin
      if (t < 20) begin
        b[t] = w[19-t] ^ w[32-t];
      end else begin
        b[t] = w[39-t] ^ w[52-t] ^ w[32-t];
      end
    end
    for (int i = 0; i < 32; i++) begin
      nxt.shift[i] = b[31-i];
    end
    nxt.overflow = w[0];
    return nxt;
  endfunction

  function automatic logic [WordWidth-1:0] byte_reverse(input logic [WordWidth-1:0] r);
    return {r[7:0], r[15:8], r[23:16], r[31:24]};
  endfunction

endpackage

// ----- design/lfsr33_core.sv -----
// Generator state, request decode, LFSR advance and integer scaling for one word.
module lfsr33_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                fire,
  input  logic [lfsr33_pkg::WordWidth-1:0]    arg,
  output lfsr33_pkg::result_t                 res
);

  lfsr33_pkg::lfsr_state_t state;
  lfsr33_pkg::lfsr_state_t state_next;
  lfsr33_pkg::lfsr_state_t stepped;
  logic [lfsr33_pkg::WordWidth-1:0] frac_stepped;
  logic [lfsr33_pkg::WordWidth+lfsr33_pkg::ScaledWidth-1:0] product;

  assign stepped      = lfsr33_pkg::advance32(state);
  assign frac_stepped = lfsr33_pkg::byte_reverse(stepped.shift);
  assign product      = frac_stepped * arg[lfsr33_pkg::ScaledWidth-1:0];

  always_comb begin
    state_next   = state;
    res.kind     = lfsr33_pkg::KIND_FRACTION;
    res.fraction = '0;
    res.scaled   = '0;
    if (arg[lfsr33_pkg::WordWidth-1]) begin
      state_next.shift    = arg;
      state_next.overflow = 1'b0;
      res.kind            = lfsr33_pkg::KIND_SEED;
    end else if (arg == '0) begin
      res.fraction = lfsr33_pkg::byte_reverse(state.shift);
    end else if (arg == lfsr33_pkg::WordWidth'(1)) begin
      state_next   = stepped;
      res.fraction = frac_stepped;
    end else begin
      state_next   = stepped;
      res.kind     = lfsr33_pkg::KIND_INTEGER;
      res.fraction = frac_stepped;
      res.scaled   = product[lfsr33_pkg::WordWidth +: lfsr33_pkg::ScaledWidth]
                     + lfsr33_pkg::ScaledWidth'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

endmodule

// ----- design/lfsr33_random_generator.sv -----
// Top level of the 33-bit LFSR random generator: input register, core and result register.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+--------------------------------------------
//   in      | in_valid, in_stall  | argument
//   out     | out_valid, out_stall| result_kind, fraction, scaled_value
//
// From acceptance a word passes through the input register, then through the LFSR network
// and the 32 by 31 multiplier into the result register.
// One word is accepted in every cycle when the output is not stalled.
// Reset clears the generator state and both valid flags; the first word may enter
// in the cycle after reset falls.
// While the result waits under out_stall, one more word is held in the input register.
module lfsr33_random_generator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [lfsr33_pkg::WordWidth-1:0]      argument,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [lfsr33_pkg::KindWidth-1:0]      result_kind,
  output logic [lfsr33_pkg::WordWidth-1:0]      fraction,
  output logic [lfsr33_pkg::ScaledWidth-1:0]    scaled_value
);

  logic                              arg_valid;
  logic [lfsr33_pkg::WordWidth-1:0]  arg;
  logic                              adv_out;
  logic                              core_fire;
  lfsr33_pkg::result_t               core_res;

  assign adv_out   = !out_valid || !out_stall;
  assign core_fire = arg_valid && adv_out;
  assign in_stall  = arg_valid && !adv_out;

  lfsr33_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (core_fire),
    .arg  (arg),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      arg_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        arg_valid <= in_valid;
      end
      if (adv_out) begin
        out_valid <= arg_valid;
      end
    end
    if (in_valid && !in_stall) begin
      arg <= argument;
    end
    if (core_fire) begin
      result_kind  <= core_res.kind;
      fraction     <= core_res.fraction;
      scaled_value <= core_res.scaled;
    end
  end

  a_seed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == lfsr33_pkg::KIND_SEED |-> fraction == '0 && scaled_value == '0)
    else $error("Seed result carries a nonzero payload.");

  a_frac_unscaled: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == lfsr33_pkg::KIND_FRACTION |-> scaled_value == '0)
    else $error("Fraction result carries a scaled value.");

  a_int_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == lfsr33_pkg::KIND_INTEGER |-> scaled_value != '0)
    else $error("Integer result is zero.");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> arg_valid && out_valid)
    else $error("Input stalled without a held word and a waiting result.");

  a_fire_delivers: assert property (@(posedge clk) disable iff (rst)
    core_fire |=> out_valid)
    else $error("Processed word did not reach the result register.");

endmodule

// ----- verif/lfsr33_random_generator_tb.sv -----
// Self-checking testbench for the 33-bit LFSR random generator, table-driven then random.
module lfsr33_random_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 400;
  localparam int unsigned RandomWords = 900;
  localparam int unsigned DirectedWords = 23;

  typedef struct packed {
    logic [lfsr33_pkg::WordWidth-1:0] arg;
    logic                             fixed;
    lfsr33_pkg::result_t              res;
  } stim_row_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [lfsr33_pkg::WordWidth-1:0]   argument = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [lfsr33_pkg::KindWidth-1:0]   result_kind;
  logic [lfsr33_pkg::WordWidth-1:0]   fraction;
  logic [lfsr33_pkg::ScaledWidth-1:0] scaled_value;

  logic                               row_fixed = 1'b0;
  lfsr33_pkg::result_t                row_res = '0;
  logic                               quiet = 1'b0;

  lfsr33_pkg::lfsr_state_t            gen_state;
  lfsr33_pkg::result_t                pending_results[$];
  lfsr33_pkg::result_t                want;
  logic [lfsr33_pkg::WordWidth-1:0]   swapped;
  logic [63:0]                        product;
  int unsigned                        error_count = 0;
  int unsigned                        idle_cycles = 0;
  stim_row_t                          directed_rows[DirectedWords];

  lfsr33_random_generator dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .argument     (argument),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .fraction     (fraction),
    .scaled_value (scaled_value)
  );

  always #2 clk = ~clk;

  function automatic lfsr33_pkg::lfsr_state_t run_lfsr32(input lfsr33_pkg::lfsr_state_t s);
    logic fb;
    for (int i = 0; i < 32; i++) begin
      fb = s.shift[19] ^ s.overflow;
      s.overflow = s.shift[31];
      s.shift = {s.shift[30:0], fb};
    end
    return s;
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [lfsr33_pkg::WordWidth-1:0] got,
                                 input logic [lfsr33_pkg::WordWidth-1:0] exp_val);
    $display("%0t: %s: got %h, wanted %h", $realtime, what, got, exp_val);
    error_count++;
  endtask

  // Predict each accepted word and check each accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      gen_state = '0;
    end else begin
      if (in_valid && !in_stall) begin
        want = '0;
        if (argument[lfsr33_pkg::WordWidth-1]) begin
          gen_state.shift = argument;
          gen_state.overflow = 1'b0;
          want.kind = lfsr33_pkg::KIND_SEED;
        end else begin
          if (argument != 0) begin
            gen_state = run_lfsr32(gen_state);
          end
          swapped = {gen_state.shift[7:0], gen_state.shift[15:8],
                     gen_state.shift[23:16], gen_state.shift[31:24]};
          want.fraction = swapped;
          want.kind = lfsr33_pkg::KIND_FRACTION;
          if (argument > 1) begin
            product = {32'd0, swapped} * {32'd0, argument};
            want.kind = lfsr33_pkg::KIND_INTEGER;
            want.scaled = product[62:32] + 31'd1;
          end
        end
        pending_results.push_back(row_fixed ? row_res : want);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected", fraction, '0);
        end else begin
          want = pending_results.pop_front();
          if (result_kind !== want.kind)
            report_mismatch("result_kind", 32'(result_kind), 32'(want.kind));
          if (fraction !== want.fraction)
            report_mismatch("fraction", fraction, want.fraction);
          if (scaled_value !== want.scaled)
            report_mismatch("scaled_value", 32'(scaled_value), 32'(want.scaled));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no word moved for %0d cycles", $realtime, idle_cycles);
      $display("lfsr33_random_generator regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned n;
    forever begin
      n = quiet ? 0 : $urandom_range(0, 15);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_word(input logic [lfsr33_pkg::WordWidth-1:0] arg, input logic fixed,
                           input lfsr33_pkg::result_t res);
    int unsigned n;
    n = quiet ? 0 : $urandom_range(0, 15);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid  <= 1'b1;
    argument  <= arg;
    row_fixed <= fixed;
    row_res   <= res;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  initial begin
    logic [lfsr33_pkg::WordWidth-1:0] arg;
    int unsigned                      sel;

    directed_rows[0]  = '{32'h0000_0000, 1'b1,
                          '{lfsr33_pkg::KIND_FRACTION, 32'h0, 31'd0}};
    directed_rows[1]  = '{32'h0000_0001, 1'b1,
                          '{lfsr33_pkg::KIND_FRACTION, 32'h0, 31'd0}};
    directed_rows[2]  = '{32'h0000_0002, 1'b1,
                          '{lfsr33_pkg::KIND_INTEGER, 32'h0, 31'd1}};
    directed_rows[3]  = '{32'h7FFF_FFFF, 1'b1,
                          '{lfsr33_pkg::KIND_INTEGER, 32'h0, 31'd1}};
    directed_rows[4]  = '{32'h8000_0000, 1'b1,
                          '{lfsr33_pkg::KIND_SEED, 32'h0, 31'd0}};
    directed_rows[5]  = '{32'h0000_0000, 1'b1,
                          '{lfsr33_pkg::KIND_FRACTION, 32'h0000_0080, 31'd0}};
    directed_rows[6]  = '{32'h0000_0001, 1'b0, '0};
    directed_rows[7]  = '{32'h7FFF_FFFF, 1'b0, '0};
    directed_rows[8]  = '{32'hFFFF_FFFF, 1'b1,
                          '{lfsr33_pkg::KIND_SEED, 32'h0, 31'd0}};
    directed_rows[9]  = '{32'h0000_0000, 1'b1,
                          '{lfsr33_pkg::KIND_FRACTION, 32'hFFFF_FFFF, 31'd0}};
    directed_rows[10] = '{32'h7FFF_FFFF, 1'b0, '0};
    directed_rows[11] = '{32'h0000_0002, 1'b0, '0};
    directed_rows[12] = '{32'h0000_0003, 1'b0, '0};
    directed_rows[13] = '{32'h0000_0000, 1'b0, '0};
    directed_rows[14] = '{32'h89AB_CDEF, 1'b1,
                          '{lfsr33_pkg::KIND_SEED, 32'h0, 31'd0}};
    directed_rows[15] = '{32'h0000_0000, 1'b1,
                          '{lfsr33_pkg::KIND_FRACTION, 32'hEFCD_AB89, 31'd0}};
    directed_rows[16] = '{32'h4000_0000, 1'b0, '0};
    directed_rows[17] = '{32'h0000_0001, 1'b0, '0};
    directed_rows[18] = '{32'h0001_0000, 1'b0, '0};
    directed_rows[19] = '{32'hC000_0001, 1'b1,
                          '{lfsr33_pkg::KIND_SEED, 32'h0, 31'd0}};
    directed_rows[20] = '{32'h5555_5555, 1'b0, '0};
    directed_rows[21] = '{32'h2AAA_AAAA, 1'b0, '0};
    directed_rows[22] = '{32'h0000_0000, 1'b0, '0};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].arg, directed_rows[i].fixed, directed_rows[i].res);
    end

    // Hold off until the directed words have all been answered.
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);

    for (int i = 0; i < RandomWords; i++) begin
      quiet = ((i / 150) % 3) == 1;
      sel = $urandom_range(0, 99);
      arg = $urandom();
      if (sel < 8) begin
        arg[lfsr33_pkg::WordWidth-1] = 1'b1;
      end else if (sel < 10) begin
        arg = $urandom_range(0, 1) ? 32'h8000_0000 : 32'hFFFF_FFFF;
      end else if (sel < 22) begin
        arg = 32'h0;
      end else if (sel < 40) begin
        arg = 32'h1;
      end else if (sel < 50) begin
        arg = $urandom_range(2, 16);
      end else if (sel < 60) begin
        arg = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h7FFF_FFFE;
      end else begin
        arg[lfsr33_pkg::WordWidth-1] = 1'b0;
      end
      send_word(arg, 1'b0, '0);
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (8) @(posedge clk);

    if (pending_results.size() != 0)
      report_mismatch("results still expected at end", 32'(pending_results.size()), '0);

    if (error_count == 0) begin
      $display("lfsr33_random_generator regression: pass");
    end else begin
      $display("lfsr33_random_generator regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/lfsr33_pkg.sv
design/lfsr33_core.sv
design/lfsr33_random_generator.sv
verif/lfsr33_random_generator_tb.sv
